FILE: src/imfr_pkg.sv
package imfr_pkg;

	localparam int MaxItems = 16;
	localparam int NumRegs  = 6;

	localparam logic [7:0]  Preamble   = 8'hFA;
	localparam logic [7:0]  BusMaster  = 8'hFF;
	localparam logic [7:0]  BusFirst   = 8'h01;
	localparam logic [15:0] StatusId   = 16'hE010;
	localparam logic [7:0]  SizeBadMsk = 8'hE1;

	localparam logic [2:0] EV_WORD     = 3'd0;
	localparam logic [2:0] EV_FRAME_OK = 3'd1;
	localparam logic [2:0] EV_BAD_CS   = 3'd2;
	localparam logic [2:0] EV_ACK      = 3'd3;
	localparam logic [2:0] EV_FLAGS    = 3'd4;
	localparam logic [2:0] EV_OUTCFG   = 3'd5;
	localparam logic [2:0] EV_ABORT    = 3'd6;

	localparam logic [2:0] REG_DATA   = 3'd0;
	localparam logic [2:0] REG_WAKEUP = 3'd1;
	localparam logic [2:0] REG_CFGACK = 3'd2;
	localparam logic [2:0] REG_MEAS   = 3'd3;
	localparam logic [2:0] REG_FLAGS  = 3'd4;
	localparam logic [2:0] REG_OUTCFG = 3'd5;

	typedef struct packed {
		logic [4:0]  item_count;
		logic [7:0]  status_byte;
		logic [31:0] option_flags;
		logic [1:0]  ack_which;
		logic        item_last;
		logic [31:0] word_value;
		logic [2:0]  word_index;
		logic [4:0]  item_size;
		logic [15:0] item_id;
		logic [2:0]  event_res;
	} result_t;

endpackage

FILE: src/imu_frame_receiver_top.sv
// IMU reply frame receiver.
// s_axis: one received serial byte per word (tdata[7:0]).
// m_axis: one result word per event; tdata carries the result fields packed.
// cfg: write channel (cfg_index, cfg_data) for the six message id registers;
//   write only while the block is idle. cfg_ready is always high.
// Each accepted byte is parsed in the cycle it is taken; a result, if any,
// appears on m_axis in the next cycle. One byte per cycle is sustained while
// m_axis_tready is high: the single result register acts as the stage between
// input and output, and s_axis_tready stays high while it is empty or being taken.
// When the receiver stalls m_axis_tready, the result holds and s_axis_tready
// drops until it is taken; bytes that give no result still need that slot
// free, since the next byte may produce one.
// Reset: parser hunts for the preamble, all parser state cleared, id registers
// take their defaults (54, 62, 49, 17, 73, 193), no result pending.
// Frame: 0xFA, bus id 0xFF/0x01, message id, length, payload, checksum.
// Data frames split into items (id, size, data words big-endian); status
// item 0xE010 updates the status byte carried in every result.
module imu_frame_receiver_top (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [7:0]   s_axis_tdata,   // [7:0] rx_byte
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// [2:0] event_res, [18:3] item_id, [23:19] item_size, [26:24] word_index,
	// [58:27] word_value, [59] item_last, [61:60] ack_which,
	// [93:62] option_flags, [101:94] status_byte, [106:102] item_count,
	// [111:107] zero
	output logic [111:0] m_axis_tdata,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [2:0]   cfg_index,
	input  logic [7:0]   cfg_data
);

	typedef enum logic [3:0] {
		PH_HUNT, PH_BUS, PH_MSGID, PH_LEN, PH_ITEM_HI, PH_ITEM_LO, PH_ITEM_SIZE,
		PH_STATUS_SIZE, PH_STATUS_VAL, PH_ITEM_DATA, PH_ACK_CS, PH_FLAGS_DATA,
		PH_OUTCFG_DATA, PH_FINAL_CS
	} phase_t;

	phase_t      phase_q, phase_d;
	logic [7:0]  cfg_q [imfr_pkg::NumRegs];
	logic [7:0]  sum_q, sum_d, len_q, len_d, cnt_q, cnt_d, status_q, status_d;
	logic [2:0]  kind_q, kind_d;
	logic [15:0] id_q, id_d;
	logic [4:0]  size_q, size_d, sub_q, sub_d, done_q, done_d;
	logic [31:0] acc_q, acc_d, flags_q, flags_d;

	imfr_pkg::result_t res_d, res_q;
	logic res_v_d, res_vld_q;

	logic       take;
	logic [7:0] c, sum_add, left;
	logic [1:0] pos;
	logic [4:0] sub_inc;
	logic       last, found;
	logic [2:0] hit;

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = !res_vld_q || m_axis_tready;
	assign take          = s_axis_tvalid && s_axis_tready;
	assign c             = s_axis_tdata;
	assign sum_add       = sum_q + c;
	assign m_axis_tvalid = res_vld_q;
	assign m_axis_tdata  = {5'd0, res_q};

	// first matching register wins
	always_comb begin
		found = 1'b0;
		hit   = imfr_pkg::REG_DATA;
		for (int k = imfr_pkg::NumRegs - 1; k >= 0; k--) begin
			if (c == cfg_q[k]) begin
				found = 1'b1;
				hit   = 3'(k);
			end
		end
	end

	always_comb begin
		phase_d  = phase_q;
		sum_d    = sum_q;
		len_d    = len_q;
		cnt_d    = cnt_q;
		kind_d   = kind_q;
		id_d     = id_q;
		size_d   = size_q;
		sub_d    = sub_q;
		acc_d    = acc_q;
		flags_d  = flags_q;
		done_d   = done_q;
		status_d = status_q;
		res_v_d  = 1'b0;
		res_d    = '0;
		left     = len_q - cnt_q;
		pos      = sub_q[1:0];
		sub_inc  = sub_q + 5'd1;
		last     = (sub_inc == size_q);
		if (phase_q != PH_HUNT && phase_q != PH_BUS)
			sum_d = sum_add;
		unique case (phase_q)
			PH_HUNT: begin
				if (c == imfr_pkg::Preamble) phase_d = PH_BUS;
			end
			PH_BUS: begin
				if (c == imfr_pkg::BusMaster || c == imfr_pkg::BusFirst) begin
					sum_d   = c;
					phase_d = PH_MSGID;
				end else if (c != imfr_pkg::Preamble) begin
					phase_d = PH_HUNT;
				end
			end
			PH_MSGID: begin
				phase_d = found ? PH_LEN : PH_HUNT;
				if (found) kind_d = hit;
			end
			PH_LEN: begin
				phase_d = PH_HUNT;
				cnt_d   = '0;
				unique case (kind_q)
					imfr_pkg::REG_DATA: begin
						len_d  = c;
						done_d = '0;
						sub_d  = '0;
						if (c != 8'd0) phase_d = PH_ITEM_HI;
					end
					imfr_pkg::REG_WAKEUP, imfr_pkg::REG_CFGACK, imfr_pkg::REG_MEAS: begin
						if (c == 8'd0) phase_d = PH_ACK_CS;
					end
					imfr_pkg::REG_FLAGS: begin
						if (c == 8'd0) begin
							phase_d = PH_ACK_CS;
						end else if (c == 8'd4) begin
							flags_d = '0;
							phase_d = PH_FLAGS_DATA;
						end
					end
					default: begin
						if (c == 8'd12) phase_d = PH_OUTCFG_DATA;
					end
				endcase
			end
			PH_ITEM_HI: begin
				if (cnt_q == len_q) begin
					phase_d         = PH_HUNT;
					res_v_d         = 1'b1;
					res_d.event_res = (sum_add == 8'd0) ? imfr_pkg::EV_FRAME_OK
					                                    : imfr_pkg::EV_BAD_CS;
					res_d.item_count = done_q;
				end else if (cnt_q > len_q || left < 8'd3) begin
					phase_d          = PH_HUNT;
					res_v_d          = 1'b1;
					res_d.event_res  = imfr_pkg::EV_ABORT;
					res_d.item_count = done_q;
				end else begin
					cnt_d   = cnt_q + 8'd1;
					id_d    = {c, 8'd0};
					phase_d = PH_ITEM_LO;
				end
			end
			PH_ITEM_LO: begin
				cnt_d   = cnt_q + 8'd1;
				id_d    = {id_q[15:8], c};
				phase_d = ({id_q[15:8], c} == imfr_pkg::StatusId) ? PH_STATUS_SIZE
				                                                  : PH_ITEM_SIZE;
			end
			PH_ITEM_SIZE: begin
				cnt_d = cnt_q + 8'd1;
				if ((c & imfr_pkg::SizeBadMsk) != 8'd0 || c > (left - 8'd1)) begin
					phase_d          = PH_HUNT;
					res_v_d          = 1'b1;
					res_d.event_res  = imfr_pkg::EV_ABORT;
					res_d.item_count = done_q;
				end else begin
					size_d = c[4:0];
					sub_d  = '0;
					if (c == 8'd0) begin
						if (done_q < 5'(imfr_pkg::MaxItems)) done_d = done_q + 5'd1;
						phase_d = PH_ITEM_HI;
					end else begin
						phase_d = PH_ITEM_DATA;
					end
				end
			end
			PH_STATUS_SIZE: begin
				cnt_d = cnt_q + 8'd1;
				if (c != 8'd1 || (cnt_q + 8'd1) >= len_q) begin
					phase_d          = PH_HUNT;
					res_v_d          = 1'b1;
					res_d.event_res  = imfr_pkg::EV_ABORT;
					res_d.item_count = done_q;
				end else begin
					size_d  = 5'd1;
					phase_d = PH_STATUS_VAL;
				end
			end
			PH_STATUS_VAL: begin
				cnt_d    = cnt_q + 8'd1;
				status_d = c;
				phase_d  = PH_ITEM_HI;
			end
			PH_ITEM_DATA: begin
				cnt_d = cnt_q + 8'd1;
				acc_d = (pos == 2'd0) ? 32'd0 : acc_q;
				case (pos)
					2'd0:    acc_d[31:24] = c;
					2'd1:    acc_d[23:16] = c;
					2'd2:    acc_d[15:8]  = c;
					default: acc_d[7:0]   = c;
				endcase
				sub_d = sub_inc;
				if (last) begin
					if (done_q < 5'(imfr_pkg::MaxItems)) done_d = done_q + 5'd1;
					phase_d = PH_ITEM_HI;
				end
				if (pos == 2'd3 || last) begin
					res_v_d          = 1'b1;
					res_d.event_res  = imfr_pkg::EV_WORD;
					res_d.item_id    = id_q;
					res_d.item_size  = size_q;
					res_d.word_index = sub_q[4:2];
					res_d.word_value = acc_d;
					res_d.item_last  = last;
				end
			end
			PH_ACK_CS: begin
				phase_d = PH_HUNT;
				if (sum_add == 8'd0) begin
					res_v_d         = 1'b1;
					res_d.event_res = imfr_pkg::EV_ACK;
					res_d.ack_which = 2'(kind_q - 3'd1);
				end
			end
			PH_FLAGS_DATA: begin
				flags_d = {flags_q[23:0], c};
				cnt_d   = cnt_q + 8'd1;
				if (cnt_q + 8'd1 >= 8'd4) phase_d = PH_FINAL_CS;
			end
			PH_OUTCFG_DATA: begin
				cnt_d = cnt_q + 8'd1;
				if (cnt_q + 8'd1 >= 8'd12) phase_d = PH_FINAL_CS;
			end
			PH_FINAL_CS: begin
				phase_d = PH_HUNT;
				if (sum_add == 8'd0) begin
					res_v_d = 1'b1;
					if (kind_q == imfr_pkg::REG_FLAGS) begin
						res_d.event_res    = imfr_pkg::EV_FLAGS;
						res_d.option_flags = flags_q;
					end else begin
						res_d.event_res = imfr_pkg::EV_OUTCFG;
					end
				end
			end
			default: phase_d = PH_HUNT;
		endcase
		res_d.status_byte = status_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_HUNT;
			sum_q     <= '0;
			len_q     <= '0;
			cnt_q     <= '0;
			kind_q    <= '0;
			id_q      <= '0;
			size_q    <= '0;
			sub_q     <= '0;
			acc_q     <= '0;
			flags_q   <= '0;
			done_q    <= '0;
			status_q  <= '0;
			res_vld_q <= 1'b0;
			cfg_q[0]  <= 8'd54;
			cfg_q[1]  <= 8'd62;
			cfg_q[2]  <= 8'd49;
			cfg_q[3]  <= 8'd17;
			cfg_q[4]  <= 8'd73;
			cfg_q[5]  <= 8'd193;
		end else begin
			if (cfg_valid && cfg_index < 3'(imfr_pkg::NumRegs))
				cfg_q[cfg_index] <= cfg_data;
			if (take) begin
				phase_q  <= phase_d;
				sum_q    <= sum_d;
				len_q    <= len_d;
				cnt_q    <= cnt_d;
				kind_q   <= kind_d;
				id_q     <= id_d;
				size_q   <= size_d;
				sub_q    <= sub_d;
				acc_q    <= acc_d;
				flags_q  <= flags_d;
				done_q   <= done_d;
				status_q <= status_d;
			end
			if (take) res_vld_q <= res_v_d;
			else if (m_axis_tready) res_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take && res_v_d) res_q <= res_d;
	end

endmodule
